/* rtl/core/pkip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pkip_pkg;

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 3;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_INDEX    = 2'd0;
  localparam kind_t KIND_LENGTH   = 2'd1;
  localparam kind_t KIND_NOTINDEX = 2'd2;

  localparam logic [VALUE_W-1:0] MAX_INDEX = 32'hFFFF_FFF9;

  localparam logic [COUNT_W-1:0] WORD_LEN  = 3'd6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

  localparam logic [UNIT_W-1:0] UNIT_ZERO = 16'h0030;
  localparam logic [UNIT_W-1:0] UNIT_NINE = 16'h0039;

  typedef struct packed {
    logic [VALUE_W-1:0] accumulator;
    logic [COUNT_W-1:0] unit_count;
    logic               digits_invalid;
    logic               leading_zero;
    logic               word_match;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    accumulator:    '0,
    unit_count:     '0,
    digits_invalid: 1'b0,
    leading_zero:   1'b0,
    word_match:     1'b1
  };

  // Letters of the word "length" by position.
  function automatic logic [UNIT_W-1:0] word_unit(input logic [COUNT_W-1:0] pos);
    logic [UNIT_W-1:0] u;
    case (pos)
      3'd0:    u = 16'h006C;
      3'd1:    u = 16'h0065;
      3'd2:    u = 16'h006E;
      3'd3:    u = 16'h0067;
      3'd4:    u = 16'h0074;
      3'd5:    u = 16'h0068;
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/property_key_index_parser_unit.sv */
// Pipeline: an accepted unit is registered first, and the key's result is
// registered after it. Throughput: one code unit per cycle unless in_stall is
// high; the x10 add and range compare on the accumulator are combinational.
// Reset: synchronous, active low; clears both pipeline valids and the key
// state (accumulator, count and flags) back to an empty key.
`timescale 1ns / 1ps
`default_nettype none

module property_key_index_parser_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [pkip_pkg::UNIT_W-1:0]        in_code_unit,
  input  wire logic                               in_last_unit,
  input  wire logic                               in_empty_key,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output pkip_pkg::kind_t                         out_kind,
  output logic [pkip_pkg::VALUE_W-1:0]            out_index_value
);
  import pkip_pkg::*;

  logic               s1_valid_r;
  logic [UNIT_W-1:0]  s1_unit_r;
  logic               s1_last_r;
  logic               s1_empty_r;

  state_t             state_r;
  state_t             state_nxt;
  state_t             state_upd;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [VALUE_W-1:0] out_index_r;

  kind_t              res_kind;
  logic [VALUE_W-1:0] res_index;
  logic               advance;
  logic               key_end;

  pkip_step u_step (
    .state_cur   (state_r),
    .code_unit   (s1_unit_r),
    .take        (!s1_empty_r),
    .state_upd   (state_upd),
    .kind        (res_kind),
    .index_value (res_index)
  );

  // result register free, or being drained this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign key_end  = s1_empty_r || s1_last_r;

  always_comb begin
    state_nxt = state_r;
    if (s1_valid_r && advance) begin
      state_nxt = key_end ? STATE_CLEAR : state_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_CLEAR;
    end else begin
      state_r <= state_nxt;
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r && key_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_unit_r  <= in_code_unit;
      s1_last_r  <= in_last_unit;
      s1_empty_r <= in_empty_key;
    end
    if (advance && s1_valid_r && key_end) begin
      out_kind_r  <= res_kind;
      out_index_r <= res_index;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_index_value = out_index_r;

endmodule

`default_nettype wire

/* rtl/core/pkip_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module pkip_step (
  input  wire pkip_pkg::state_t                  state_cur,
  input  wire logic [pkip_pkg::UNIT_W-1:0]       code_unit,
  input  wire logic                              take,
  output pkip_pkg::state_t                       state_upd,
  output pkip_pkg::kind_t                        kind,
  output logic [pkip_pkg::VALUE_W-1:0]           index_value
);
  import pkip_pkg::*;

  logic               is_digit;
  logic [3:0]         digit;
  logic [VALUE_W+3:0] prod;
  state_t             st;

  assign is_digit = (code_unit >= UNIT_ZERO) && (code_unit <= UNIT_NINE);
  assign digit    = code_unit[3:0];
  // acc * 10 + digit as two shifted adds
  assign prod = {1'b0, state_cur.accumulator, 3'b000}
              + {3'b000, state_cur.accumulator, 1'b0}
              + {{VALUE_W{1'b0}}, digit};

  always_comb begin
    st = state_cur;
    if (take) begin
      if ((state_cur.unit_count >= WORD_LEN) ||
          (code_unit != word_unit(state_cur.unit_count))) begin
        st.word_match = 1'b0;
      end
      if (!is_digit) begin
        st.digits_invalid = 1'b1;
      end else if (state_cur.unit_count == '0) begin
        if (digit == 4'd0) begin
          st.leading_zero = 1'b1;
        end
        st.accumulator = {{(VALUE_W-4){1'b0}}, digit};
      end else if (state_cur.leading_zero) begin
        st.digits_invalid = 1'b1;
      end else if (!state_cur.digits_invalid) begin
        // freeze the value once it passes the largest index
        if (prod > {4'b0000, MAX_INDEX}) begin
          st.digits_invalid = 1'b1;
        end else begin
          st.accumulator = prod[VALUE_W-1:0];
        end
      end
      if (state_cur.unit_count != COUNT_MAX) begin
        st.unit_count = state_cur.unit_count + 3'd1;
      end
    end
    state_upd = st;
  end

  always_comb begin
    index_value = '0;
    if (st.word_match && (st.unit_count == WORD_LEN)) begin
      kind = KIND_LENGTH;
    end else if ((st.unit_count != '0) && !st.digits_invalid) begin
      kind        = KIND_INDEX;
      index_value = st.accumulator;
    end else begin
      kind = KIND_NOTINDEX;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pkip_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pkip_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire pkip_pkg::kind_t               out_kind,
  input  wire logic [pkip_pkg::VALUE_W-1:0]  out_index_value
);
  import pkip_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_index_value))
    else $error("result changed while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_INDEX) || (out_kind == KIND_LENGTH) ||
                  (out_kind == KIND_NOTINDEX))
    else $error("bad result kind");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_INDEX) |-> out_index_value == '0)
    else $error("nonzero value for non-index key");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_INDEX) |-> out_index_value <= MAX_INDEX)
    else $error("index above maximum");

  // input side only stalls when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

endmodule

bind property_key_index_parser_unit pkip_checker u_pkip_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_index_value (out_index_value)
);

`default_nettype wire

/* dv/property_key_index_parser_unit_tb.sv */
`timescale 1ns / 1ps

module property_key_index_parser_unit_tb;
  import pkip_pkg::*;

  localparam int TOTAL_ITEMS = 950;
  localparam int QUIET_ITEMS = 150;
  localparam int LATENCY     = 2;
  localparam int DRAIN_LIMIT = 4000;

  typedef logic [UNIT_W-1:0] unit_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
  } key_result_t;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  unit_t               in_code_unit    = '0;
  logic                in_last_unit    = 1'b0;
  logic                in_empty_key    = 1'b0;
  logic                out_stall       = 1'b0;
  logic                in_stall;
  logic                out_valid;
  kind_t               out_kind;
  logic [VALUE_W-1:0]  out_index_value;

  // Expected key results, oldest first.
  key_result_t         key_results[$];
  key_result_t         oldest_key;

  // Predicted key state.
  logic [VALUE_W-1:0]  parsed_value;
  logic [COUNT_W-1:0]  units_seen;
  logic                not_index;
  logic                zero_first;
  logic                still_length;
  string               length_word = "length";

  unit_t               key_units[$];
  int                  items_sent  = 0;
  int                  mismatches  = 0;
  bit                  idle_on     = 1'b1;

  property_key_index_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_code_unit    (in_code_unit),
    .in_last_unit    (in_last_unit),
    .in_empty_key    (in_empty_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_index_value (out_index_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic void clear_key_state();
    parsed_value = '0;
    units_seen   = '0;
    not_index    = 1'b0;
    zero_first   = 1'b0;
    still_length = 1'b1;
  endfunction

  function automatic void predict_key_unit(unit_t cu, logic last, logic empty);
    logic [63:0] next_value;
    key_result_t res;
    if (!empty) begin
      if (units_seen >= WORD_LEN) begin
        still_length = 1'b0;
      end else if (cu != {8'h00, length_word[units_seen]}) begin
        still_length = 1'b0;
      end
      if (cu < UNIT_ZERO || cu > UNIT_NINE) begin
        not_index = 1'b1;
      end else if (units_seen == 0) begin
        if (cu == UNIT_ZERO) zero_first = 1'b1;
        parsed_value = VALUE_W'(cu - UNIT_ZERO);
      end else if (zero_first) begin
        not_index = 1'b1;
      end else if (!not_index) begin
        next_value = 64'(parsed_value);
        next_value = next_value * 10 + (cu - UNIT_ZERO);
        if (next_value > MAX_INDEX) not_index = 1'b1;
        else parsed_value = next_value[VALUE_W-1:0];
      end
      if (units_seen < COUNT_MAX) units_seen++;
    end
    if (empty || last) begin
      res.value = '0;
      if (still_length && units_seen == WORD_LEN) begin
        res.kind = KIND_LENGTH;
      end else if (units_seen != 0 && !not_index) begin
        res.kind  = KIND_INDEX;
        res.value = parsed_value;
      end else begin
        res.kind = KIND_NOTINDEX;
      end
      key_results.push_back(res);
      clear_key_state();
    end
  endfunction

  // Offer one request, hold it until accepted, then predict.
  task automatic send_request(unit_t cu, logic last, logic empty);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_unit <= cu;
    in_last_unit <= last;
    in_empty_key <= empty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_key_unit(cu, last, empty);
    items_sent++;
  endtask

  // Send the staged units; optionally close the key with an empty-key request.
  task automatic send_key(input bit close_empty);
    int n;
    n = key_units.size();
    for (int i = 0; i < n; i++) begin
      send_request(key_units[i], (i == n - 1) && !close_empty, 1'b0);
    end
    if (close_empty) send_request(unit_t'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    key_units.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) key_units.push_back({8'h00, s[i]});
  endtask

  task automatic push_digit(input int lo);
    key_units.push_back(UNIT_ZERO + unit_t'($urandom_range(lo, 9)));
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (key_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (key_results.size() != 0) begin
      oldest_key = key_results.pop_front();
      report_mismatch($sformatf("missing result kind=%0d value=%0d",
                                oldest_key.kind, oldest_key.value));
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (key_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d value=%0d",
                                  out_kind, out_index_value));
      end else begin
        oldest_key = key_results.pop_front();
        if (out_kind !== oldest_key.kind)
          report_mismatch($sformatf("kind got %0d want %0d", out_kind, oldest_key.kind));
        if (out_index_value !== oldest_key.value)
          report_mismatch($sformatf("index_value got %0d want %0d",
                                    out_index_value, oldest_key.value));
      end
    end
  end

  // Result side backpressure.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic test_length_word();
    push_text("length");
    send_key(1'b0);
    // close the word with an empty-key request instead of a last unit
    push_text("length");
    send_key(1'b1);
  endtask

  task automatic test_index_extremes();
    push_text("0");
    send_key(1'b0);
    push_text("07");
    send_key(1'b0);
    push_text("4294967290");
    send_key(1'b0);
  endtask

  task automatic test_bad_units();
    send_request(16'hFFFF, 1'b1, 1'b0);
    send_request(16'h002F, 1'b1, 1'b0);
    send_request(16'h003A, 1'b1, 1'b0);
    send_request(16'h0135, 1'b1, 1'b0);
    // empty key ends the key even with last low
    send_request(16'hFFFF, 1'b0, 1'b1);
    send_request(16'h0000, 1'b1, 1'b1);
  endtask

  task automatic test_random_keys();
    int               pick;
    int               pos;
    longint unsigned  v;
    bit               close_empty;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      pick        = $urandom_range(0, 99);
      close_empty = ($urandom_range(0, 7) == 0);
      if (pick < 40) begin
        case ($urandom_range(0, 3))
          0:       v = 64'($urandom_range(0, 999));
          1:       v = 64'($urandom);
          2:       v = longint'(MAX_INDEX) - 3 + $urandom_range(0, 6);
          default: v = {$urandom, $urandom} % 64'd1_000_000_000_000;
        endcase
        push_text($sformatf("%0d", v));
      end else if (pick < 50) begin
        push_text("0");
        repeat ($urandom_range(0, 3)) push_digit(0);
      end else if (pick < 60) begin
        push_text("length");
        case ($urandom_range(0, 3))
          0: ;
          1: key_units[$urandom_range(0, 5)] = unit_t'($urandom);
          2: repeat ($urandom_range(1, 5)) void'(key_units.pop_back());
          default: key_units.push_back(unit_t'($urandom));
        endcase
      end else if (pick < 70) begin
        push_digit(1);
        repeat ($urandom_range(0, 7)) push_digit(0);
        pos = $urandom_range(0, key_units.size() - 1);
        case ($urandom_range(0, 2))
          0:       key_units[pos] = 16'h002F;
          1:       key_units[pos] = 16'h003A;
          default: key_units[pos] = unit_t'($urandom_range(16'h003A, 16'hFFFF));
        endcase
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 9)) key_units.push_back(unit_t'($urandom));
      end else if (pick < 85) begin
        close_empty = 1'b1;
      end else if (pick < 90) begin
        push_digit(1);
        repeat ($urandom_range(0, 3)) push_digit(0);
        pos = $urandom_range(0, key_units.size() - 1);
        key_units[pos][15:8] = 8'($urandom_range(1, 255));
      end else begin
        push_digit(1);
        repeat ($urandom_range(6, 11)) push_digit(0);
      end
      send_key(close_empty);
    end
  endtask

  initial begin
    clear_key_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_length_word();
    wait_for_results();
    test_index_extremes();
    wait_for_results();
    test_bad_units();
    wait_for_results();
    test_random_keys();
    wait_for_results();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
